// File: hdl/sss_pkg.sv
// servo sweep sequencer shared package
// types, opcodes, mode codes, register indexes and field widths
// no dependencies
package sss_pkg;

  localparam int ANGLE_W   = 9;
  localparam int PULSE_W   = 15;
  localparam int STEP_W    = 10;
  localparam int MODE_W    = 3;
  localparam int DELAY_W   = 16;
  localparam int OP_W      = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int FLAG_W    = 2;
  localparam int IN_DATA_W = 16;

  // signed product position * pulse span, its magnitude, signed pulse
  localparam int PROD_W    = 26;
  localparam int MAG_W     = 24;
  localparam int PULSE_S_W = 26;

  localparam logic [OP_W-1:0] OP_STEP  = 3'd0;
  localparam logic [OP_W-1:0] OP_MS    = 3'd1;
  localparam logic [OP_W-1:0] OP_START = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd3;
  localparam logic [OP_W-1:0] OP_SET   = 3'd4;

  localparam logic [MODE_W-1:0] MODE_OS_CW  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_OS_CCW = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OW_CW  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OW_CCW = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BIDIR  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PAUSE  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_ANGLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_MODE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_DELAY    = 3'd7;

  localparam logic [ANGLE_W-1:0]       RST_MAX_ANGLE   = 9'd180;
  localparam logic [ANGLE_W-1:0]       RST_START_ANGLE = 9'd0;
  localparam logic [ANGLE_W-1:0]       RST_STOP_ANGLE  = 9'd180;
  localparam logic [PULSE_W-1:0]       RST_MIN_PULSE   = 15'd500;
  localparam logic [PULSE_W-1:0]       RST_MAX_PULSE   = 15'd2500;
  localparam logic signed [STEP_W-1:0] RST_ANGLE_STEP  = 10'sd1;
  localparam logic [MODE_W-1:0]        RST_INIT_MODE   = MODE_OW_CW;
  localparam logic [DELAY_W-1:0]       RST_FB_DELAY    = 16'd1000;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // take the input request
    logic apply;      // commit the state update
    logic mul1;       // position * pulse span
    logic div_start;  // launch the divider by max angle
    logic mul2;       // pulse -> scaled duty numerator
    logic scale;      // reciprocal multiply by the period
    logic load_out;   // fill the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// File: hdl/servo_sweep_sequencer_unit.sv
// servo sweep sequencer top level
// depends on sss_pkg, sss_ctrl, sss_datapath (and sss_divider below it)
//
// usage
//   s_* stream: one request per command; s_tuser carries the opcode
//     (step tick, millisecond tick, start, stop, set position), s_tdata
//     the requested angle for set position
//   m_* stream: exactly one result per request; m_tdata carries position,
//     duty, running and the active mode, m_tuser the updated/error flags
//   cfg_* port: single-cycle register writes, only while the block is idle
// timing
//   each request passes from acceptance through the bit-serial divide by
//   max angle to a valid result; the period scaling is a reciprocal
//   multiply; ready returns in the same cycle that the result turns valid,
//   so a new request is taken only once the last one is loaded into the
//   output register; one request is in flight at a time
//   the output register lets the next request enter while a result waits
// reset
//   synchronous rst restores the configuration, sweep state, controller and
//   output valid to their documented defaults: position 0, stopped, no pause pending, no result pending
// stall
//   when m_tready stays low the finished result holds in the output
//   register; the following request is accepted and processed but waits
//   for the output register before it completes
module servo_sweep_sequencer_unit #(
  parameter int DUTY_BITS = 10,
  parameter int PERIOD_US = 20000
) (
  input  logic                               clk,
  input  logic                               rst,
  // request side
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [sss_pkg::IN_DATA_W-1:0]      s_tdata,  // [8:0] angle
  input  logic [sss_pkg::OP_W-1:0]           s_tuser,  // [2:0] opcode
  // result side
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // position [8:0], duty [8+DUTY_BITS:9], running, active_mode, zero fill
  output logic [((13 + DUTY_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  output logic [sss_pkg::FLAG_W-1:0]         m_tuser,  // [0] updated, [1] error
  // register writes
  input  logic                               cfg_we,
  input  logic [sss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sss_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int OUT_W = ((13 + DUTY_BITS + 7) / 8) * 8;

  sss_pkg::cmd_t    cmd;
  sss_pkg::status_t status;

  // controller only sequences; all sweep and configuration state lives in the datapath
  sss_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  // sweep state, configuration, duty mapping and result register
  sss_datapath #(
    .DUTY_BITS(DUTY_BITS),
    .PERIOD_US(PERIOD_US),
    .OUT_W    (OUT_W)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_opcode(s_tuser),
    .in_angle (s_tdata[sss_pkg::ANGLE_W-1:0]),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: hdl/sss_divider.sv
// iterative restoring divider, one quotient bit per cycle
// depends on nothing; used by sss_datapath
module sss_divider #(
  parameter int DVD_W = 25,
  parameter int DVS_W = 15
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem, quo[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

endmodule

// File: hdl/sss_datapath.sv
// servo sweep datapath: registers, sweep state, duty mapping, output register
// depends on sss_pkg and sss_divider
module sss_datapath #(
  parameter int DUTY_BITS = 10,
  parameter int PERIOD_US = 20000,
  parameter int OUT_W     = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sss_pkg::cmd_t                 cmd,
  output sss_pkg::status_t              status,
  input  logic [sss_pkg::OP_W-1:0]      in_opcode,
  input  logic [sss_pkg::ANGLE_W-1:0]   in_angle,
  input  logic                          cfg_we,
  input  logic [sss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sss_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [OUT_W-1:0]              m_tdata,
  output logic [sss_pkg::FLAG_W-1:0]    m_tuser
);

  localparam int PW     = $clog2(PERIOD_US + 1);
  localparam int PRD2_W = PW + DUTY_BITS;
  // ceil(2^RCP_SH / period) gives an exact floor division for numerators below 2^PRD2_W
  localparam int RCP_SH = PRD2_W + $clog2(PERIOD_US);
  localparam int RCP_W  = PRD2_W + 2;
  localparam int SPR_W  = PRD2_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((longint'(1) << RCP_SH) + longint'(PERIOD_US) - 1) / longint'(PERIOD_US));
  localparam logic [DUTY_BITS-1:0] TOP = '1;
  localparam logic signed [sss_pkg::PULSE_S_W-1:0] PERIOD_S = sss_pkg::PULSE_S_W'(PERIOD_US);
  localparam int DUTY_LO = sss_pkg::ANGLE_W;
  localparam int RUN_LO  = DUTY_LO + DUTY_BITS;
  localparam int MODE_LO = RUN_LO + 1;

  // configuration registers
  logic [sss_pkg::ANGLE_W-1:0]       max_angle, start_angle, stop_angle;
  logic [sss_pkg::PULSE_W-1:0]       min_pulse, max_pulse;
  logic signed [sss_pkg::STEP_W-1:0] angle_step;
  logic [sss_pkg::MODE_W-1:0]        initial_mode;
  logic [sss_pkg::DELAY_W-1:0]       fb_delay;

  // sweep state
  logic [sss_pkg::ANGLE_W-1:0]       position, position_next;
  logic signed [sss_pkg::STEP_W-1:0] step_value, step_next;
  logic [sss_pkg::MODE_W-1:0]        mode, mode_next;
  logic [sss_pkg::MODE_W-1:0]        prev_mode, prev_next;
  logic                              running, running_next;
  logic [sss_pkg::DELAY_W-1:0]       fb_count, fb_count_next;
  logic                              fb_armed, fb_armed_next;

  // request and flags
  logic [sss_pkg::OP_W-1:0]    op_q;
  logic [sss_pkg::ANGLE_W-1:0] ang_q;
  logic                        upd, upd_next, err, err_next;

  // motion arithmetic
  logic signed [sss_pkg::STEP_W-1:0] step_sat_neg, step_fw, step_bw;
  logic signed [11:0] pos_s, start_s, stop_s, sum_fw, sum_bw, sum_raw;

  // duty mapping
  logic signed [sss_pkg::ANGLE_W:0]   pos_sx;
  logic signed [sss_pkg::PULSE_W:0]   span;
  logic signed [sss_pkg::PROD_W-1:0]  prod1, prod1_abs;
  logic                               prod_neg;
  logic [sss_pkg::MAG_W-1:0]          q_mag;
  logic signed [sss_pkg::PULSE_S_W-1:0] q_s, min_s, pulse;
  logic [PW-1:0]                      pulse_c;
  logic [PRD2_W-1:0]                  prod2;
  logic [sss_pkg::MAG_W-1:0]          dvd;
  logic                               div_done;
  logic [sss_pkg::MAG_W-1:0]          quotient;
  logic [PRD2_W-1:0]                  scaled;
  logic [SPR_W-1:0]                   scale_prod;
  logic [DUTY_BITS-1:0]               duty_q;

  // output register fields
  logic [sss_pkg::ANGLE_W-1:0] out_pos;
  logic [DUTY_BITS-1:0]        out_duty;
  logic                        out_run;
  logic [sss_pkg::MODE_W-1:0]  out_mode;
  logic                        out_upd, out_err;

  assign step_sat_neg = (step_value == -10'sd512) ? 10'sd511 : -step_value;
  assign step_fw = step_value[sss_pkg::STEP_W-1] ? step_sat_neg : step_value;
  assign step_bw = (step_value > 10'sd0) ? -step_value : step_value;
  assign pos_s   = {3'b000, position};
  assign start_s = {3'b000, start_angle};
  assign stop_s  = {3'b000, stop_angle};
  assign sum_fw  = pos_s + {{2{step_fw[sss_pkg::STEP_W-1]}}, step_fw};
  assign sum_bw  = pos_s + {{2{step_bw[sss_pkg::STEP_W-1]}}, step_bw};
  assign sum_raw = pos_s + {{2{step_value[sss_pkg::STEP_W-1]}}, step_value};

  always_comb begin
    position_next = position;
    step_next     = step_value;
    mode_next     = mode;
    prev_next     = prev_mode;
    running_next  = running;
    fb_count_next = fb_count;
    fb_armed_next = fb_armed;
    upd_next      = 1'b0;
    err_next      = 1'b0;
    case (op_q)
      sss_pkg::OP_STEP: begin
        if (running) begin
          case (mode)
            sss_pkg::MODE_OS_CW, sss_pkg::MODE_OW_CW: begin
              step_next = step_fw;
              upd_next  = 1'b1;
              if (sum_fw <= stop_s) begin
                position_next = sum_fw[sss_pkg::ANGLE_W-1:0];
              end else if (mode == sss_pkg::MODE_OS_CW) begin
                running_next = 1'b0;
              end else begin
                position_next = '0;
                prev_next     = sss_pkg::MODE_OW_CW;
                mode_next     = sss_pkg::MODE_PAUSE;
              end
            end
            sss_pkg::MODE_OS_CCW, sss_pkg::MODE_OW_CCW: begin
              step_next = step_bw;
              upd_next  = 1'b1;
              if (sum_bw >= start_s) begin
                position_next = sum_bw[sss_pkg::ANGLE_W-1:0];
              end else if (mode == sss_pkg::MODE_OS_CCW) begin
                running_next = 1'b0;
              end else begin
                position_next = max_angle;
                prev_next     = sss_pkg::MODE_OW_CCW;
                mode_next     = sss_pkg::MODE_PAUSE;
              end
            end
            sss_pkg::MODE_BIDIR: begin
              upd_next = 1'b1;
              if (step_value[sss_pkg::STEP_W-1]) begin
                if (sum_raw > start_s) begin
                  position_next = sum_raw[sss_pkg::ANGLE_W-1:0];
                end else begin
                  position_next = '0;
                  step_next     = step_sat_neg;
                end
              end else begin
                if (sum_raw < stop_s) begin
                  position_next = sum_raw[sss_pkg::ANGLE_W-1:0];
                end else begin
                  position_next = max_angle;
                  step_next     = step_sat_neg;
                end
              end
            end
            sss_pkg::MODE_PAUSE: begin
              fb_count_next = fb_delay;
              fb_armed_next = 1'b1;
              running_next  = 1'b0;
            end
            default: begin
              running_next = 1'b0;
              upd_next     = 1'b1;
            end
          endcase
        end
      end
      sss_pkg::OP_MS: begin
        if (fb_armed) begin
          if (fb_count <= 16'd1) begin
            fb_count_next = '0;
            fb_armed_next = 1'b0;
            mode_next     = prev_mode;
            prev_next     = sss_pkg::MODE_PAUSE;
            running_next  = 1'b1;
          end else begin
            fb_count_next = fb_count - 1'b1;
          end
        end
      end
      sss_pkg::OP_START: running_next = 1'b1;
      sss_pkg::OP_STOP:  running_next = 1'b0;
      sss_pkg::OP_SET: begin
        if (ang_q > max_angle) begin
          err_next = 1'b1;
        end else begin
          position_next = ang_q;
          upd_next      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // duty: pulse = position * span / max_angle + min, duty = pulse * top / period
  assign pos_sx    = {1'b0, position};
  assign span      = {1'b0, max_pulse} - {1'b0, min_pulse};
  assign prod1     = pos_sx * span;
  assign prod1_abs = prod1[sss_pkg::PROD_W-1] ? -prod1 : prod1;

  assign q_mag = quotient;
  assign min_s = {{(sss_pkg::PULSE_S_W - sss_pkg::PULSE_W){1'b0}}, min_pulse};

  always_comb begin
    q_s = {2'b00, q_mag};
    if (prod_neg) begin
      q_s = -q_s;
    end
    pulse = (max_angle == '0) ? min_s : (q_s + min_s);
    if (pulse[sss_pkg::PULSE_S_W-1]) begin
      pulse_c = '0;
    end else if (pulse > PERIOD_S) begin
      pulse_c = PW'(PERIOD_US);
    end else begin
      pulse_c = pulse[PW-1:0];
    end
    prod2 = PRD2_W'(pulse_c) * PRD2_W'(TOP);
  end

  // division by the period as a multiply by its rounded-up reciprocal
  assign scale_prod = {{RCP_W{1'b0}}, scaled} * {{PRD2_W{1'b0}}, RCP};

  sss_divider #(
    .DVD_W(sss_pkg::MAG_W),
    .DVS_W(sss_pkg::ANGLE_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(dvd),
    .divisor (max_angle),
    .done    (div_done),
    .quotient(quotient)
  );

  assign status.div_done = div_done;
  assign status.out_free = !m_tvalid || m_tready;

  // configuration and sweep state
  always_ff @(posedge clk) begin
    if (rst) begin
      max_angle    <= sss_pkg::RST_MAX_ANGLE;
      start_angle  <= sss_pkg::RST_START_ANGLE;
      stop_angle   <= sss_pkg::RST_STOP_ANGLE;
      min_pulse    <= sss_pkg::RST_MIN_PULSE;
      max_pulse    <= sss_pkg::RST_MAX_PULSE;
      angle_step   <= sss_pkg::RST_ANGLE_STEP;
      initial_mode <= sss_pkg::RST_INIT_MODE;
      fb_delay     <= sss_pkg::RST_FB_DELAY;
      position     <= '0;
      step_value   <= sss_pkg::RST_ANGLE_STEP;
      mode         <= sss_pkg::RST_INIT_MODE;
      prev_mode    <= sss_pkg::RST_INIT_MODE;
      running      <= 1'b0;
      fb_count     <= '0;
      fb_armed     <= 1'b0;
    end else begin
      if (cmd.apply) begin
        position   <= position_next;
        step_value <= step_next;
        mode       <= mode_next;
        prev_mode  <= prev_next;
        running    <= running_next;
        fb_count   <= fb_count_next;
        fb_armed   <= fb_armed_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          sss_pkg::CFG_MAX_ANGLE:   max_angle   <= cfg_wdata[sss_pkg::ANGLE_W-1:0];
          sss_pkg::CFG_START_ANGLE: start_angle <= cfg_wdata[sss_pkg::ANGLE_W-1:0];
          sss_pkg::CFG_STOP_ANGLE:  stop_angle  <= cfg_wdata[sss_pkg::ANGLE_W-1:0];
          sss_pkg::CFG_MIN_PULSE:   min_pulse   <= cfg_wdata[sss_pkg::PULSE_W-1:0];
          sss_pkg::CFG_MAX_PULSE:   max_pulse   <= cfg_wdata[sss_pkg::PULSE_W-1:0];
          sss_pkg::CFG_ANGLE_STEP: begin
            angle_step <= cfg_wdata[sss_pkg::STEP_W-1:0];
            step_value <= cfg_wdata[sss_pkg::STEP_W-1:0];
          end
          sss_pkg::CFG_INIT_MODE: begin
            initial_mode <= cfg_wdata[sss_pkg::MODE_W-1:0];
            if (cfg_wdata[sss_pkg::MODE_W-1:0] <= sss_pkg::MODE_BIDIR) begin
              mode <= cfg_wdata[sss_pkg::MODE_W-1:0];
            end
          end
          sss_pkg::CFG_FB_DELAY: fb_delay <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // request, flags and duty pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= in_opcode;
      ang_q <= in_angle;
    end
    if (cmd.apply) begin
      upd <= upd_next;
      err <= err_next;
    end
    if (cmd.mul1) begin
      dvd      <= prod1_abs[sss_pkg::MAG_W-1:0];
      prod_neg <= prod1[sss_pkg::PROD_W-1];
    end
    if (cmd.mul2) begin
      scaled <= prod2;
    end
    if (cmd.scale) begin
      duty_q <= scale_prod[RCP_SH +: DUTY_BITS];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pos  <= position;
      out_duty <= duty_q;
      out_run  <= running;
      out_mode <= mode;
      out_upd  <= upd;
      out_err  <= err;
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[sss_pkg::ANGLE_W-1:0]             = out_pos;
    m_tdata[RUN_LO-1:DUTY_LO]                 = out_duty;
    m_tdata[RUN_LO]                           = out_run;
    m_tdata[MODE_LO+sss_pkg::MODE_W-1:MODE_LO] = out_mode;
  end

  assign m_tuser = {out_err, out_upd};

endmodule

// File: hdl/sss_ctrl.sv
// servo sweep controller: sequences update, multiply, divide and period scaling
// depends on sss_pkg
module sss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  sss_pkg::status_t status,
  output sss_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_APPLY = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_DIV1  = 4'd3;
  localparam logic [3:0] S_WAIT1 = 4'd4;
  localparam logic [3:0] S_MUL2  = 4'd5;
  localparam logic [3:0] S_SCALE = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0] state, state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT1;
      end
      S_WAIT1: begin
        if (status.div_done) begin
          state_next = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/sss_checker.sv
// port-level checks for the servo sweep sequencer
// depends on servo_sweep_sequencer_unit, attached by bind
module sss_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [sss_pkg::FLAG_W-1:0]  m_tuser
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // one request at a time: ready drops right after an accept
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in flight");

  // a stalled result keeps its flags
  a_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tuser))
    else $error("result flags changed while stalled");

  // a rejected set position never counts as an update
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("updated and error both set");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind servo_sweep_sequencer_unit sss_checker u_sss_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tuser (m_tuser)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for servo_sweep_sequencer_unit: sweep, pause and duty mapping
// depends on sss_pkg and the unit's rtl; needs nothing else
module tb_top;
  import sss_pkg::*;

  localparam int DUTY_BITS      = 10;
  localparam int PERIOD_US      = 20000;
  localparam int REPORT_W       = ((13 + DUTY_BITS + 7) / 8) * 8;
  localparam longint DUTY_TOP   = (longint'(1) << DUTY_BITS) - 1;
  localparam int STEP_CEIL      = 511;
  localparam int ANGLE_TOP      = 511;

  localparam logic [OP_W-1:0]   OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_W-1:0]   OP_UNUSED_LAST  = 3'd7;
  localparam logic [MODE_W-1:0] MODE_UNUSED     = 3'd6;
  localparam int FLAG_UPDATED = 0;
  localparam int FLAG_ERROR   = 1;

  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 100;
  localparam int PHASE_ITEMS    = 80;
  localparam int TAIL_ITEMS     = 80;
  localparam int HOLDOFF_AT_A   = 150;
  localparam int HOLDOFF_AT_B   = 470;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int CYCLE_LIMIT    = 400000;

  typedef enum logic {CMD_REQUEST, CMD_REG_WRITE} cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [OP_W-1:0]       op;
    logic [ANGLE_W-1:0]    angle;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]      reg_val;
  } sweep_cmd_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]   position;
    logic [DUTY_BITS-1:0] duty;
    logic                 running;
    logic [MODE_W-1:0]    mode;
    logic                 updated;
    logic                 error;
  } servo_report_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // [8:0] angle
  logic [OP_W-1:0]       s_tuser = '0;   // [2:0] opcode
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [REPORT_W-1:0]   m_tdata;        // position, duty, running, active_mode, zero fill
  logic [FLAG_W-1:0]     m_tuser;        // [0] updated, [1] error
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  sweep_cmd_t    pending_cmds[$];
  servo_report_t expected_reports[$];

  int request_total = 0;
  int requests_sent = 0;
  int reports_seen  = 0;
  int error_count   = 0;
  int cycle_count   = 0;

  // settings as the block holds them
  int max_angle_r   = RST_MAX_ANGLE;
  int start_angle_r = RST_START_ANGLE;
  int stop_angle_r  = RST_STOP_ANGLE;
  int min_pulse_r   = RST_MIN_PULSE;
  int max_pulse_r   = RST_MAX_PULSE;
  int fb_delay_r    = RST_FB_DELAY;

  // sweep state
  int                pos_now       = 0;
  int                step_now      = RST_ANGLE_STEP;
  logic [MODE_W-1:0] mode_now      = RST_INIT_MODE;
  logic [MODE_W-1:0] prev_mode_now = RST_INIT_MODE;
  bit                running_now   = 1'b0;
  int                fb_count      = 0;
  bit                fb_armed      = 1'b0;

  servo_sweep_sequencer_unit #(
    .DUTY_BITS(DUTY_BITS),
    .PERIOD_US(PERIOD_US)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // reversing a step of -512 would overflow the field, so it clips
  function automatic int negated_step(int s);
    return (-s > STEP_CEIL) ? STEP_CEIL : -s;
  endfunction

  function automatic int pick_idle_percent();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 15;
      default: return 45;
    endcase
  endfunction

  // advance the sweep state by one request and work out the report it yields
  function automatic servo_report_t predict_report(logic [OP_W-1:0] op,
                                                   logic [ANGLE_W-1:0] ang);
    servo_report_t r;
    int            nxt;
    longint        pulse;
    longint        duty;
    r.updated = 1'b0;
    r.error   = 1'b0;
    case (op)
      OP_STEP: if (running_now) begin
        r.updated = 1'b1;
        case (mode_now)
          MODE_OS_CW, MODE_OW_CW: begin
            if (step_now < 0) step_now = negated_step(step_now);
            nxt = pos_now + step_now;
            if (nxt <= stop_angle_r) begin
              pos_now = nxt;
            end else if (mode_now == MODE_OS_CW) begin
              running_now = 1'b0;
            end else begin
              // one-way end: wrap to zero and go into the pause
              pos_now       = 0;
              prev_mode_now = MODE_OW_CW;
              mode_now      = MODE_PAUSE;
            end
          end
          MODE_OS_CCW, MODE_OW_CCW: begin
            if (step_now > 0) step_now = -step_now;
            nxt = pos_now + step_now;
            if (nxt >= start_angle_r) begin
              pos_now = nxt;
            end else if (mode_now == MODE_OS_CCW) begin
              running_now = 1'b0;
            end else begin
              pos_now       = max_angle_r;
              prev_mode_now = MODE_OW_CCW;
              mode_now      = MODE_PAUSE;
            end
          end
          MODE_BIDIR: begin
            nxt = pos_now + step_now;
            if (step_now < 0) begin
              if (nxt > start_angle_r) begin
                pos_now = nxt;
              end else begin
                pos_now  = 0;
                step_now = negated_step(step_now);
              end
            end else if (nxt < stop_angle_r) begin
              pos_now = nxt;
            end else begin
              pos_now  = max_angle_r;
              step_now = negated_step(step_now);
            end
          end
          MODE_PAUSE: begin
            // first tick in the pause arms the millisecond countdown
            fb_count    = fb_delay_r;
            fb_armed    = 1'b1;
            running_now = 1'b0;
            r.updated   = 1'b0;
          end
          default: running_now = 1'b0;
        endcase
      end
      OP_MS: if (fb_armed) begin
        if (fb_count <= 1) begin
          fb_count      = 0;
          fb_armed      = 1'b0;
          mode_now      = prev_mode_now;
          prev_mode_now = MODE_PAUSE;
          running_now   = 1'b1;
        end else begin
          fb_count--;
        end
      end
      OP_START: running_now = 1'b1;
      OP_STOP:  running_now = 1'b0;
      OP_SET: begin
        if (ang > max_angle_r) begin
          r.error = 1'b1;
        end else begin
          pos_now   = ang;
          r.updated = 1'b1;
        end
      end
      default: ;
    endcase

    // angle -> pulse width -> duty count, both divisions truncate toward zero
    if (max_angle_r == 0) begin
      pulse = min_pulse_r;
    end else begin
      pulse = longint'(pos_now) * (longint'(max_pulse_r) - longint'(min_pulse_r))
              / longint'(max_angle_r) + longint'(min_pulse_r);
    end
    if (pulse < 0) begin
      duty = 0;
    end else begin
      duty = pulse * DUTY_TOP / PERIOD_US;
      if (duty > DUTY_TOP) duty = DUTY_TOP;
    end

    r.position = pos_now[ANGLE_W-1:0];
    r.duty     = duty[DUTY_BITS-1:0];
    r.running  = running_now;
    r.mode     = mode_now;
    return r;
  endfunction

  task automatic queue_request(logic [OP_W-1:0] op, int ang);
    sweep_cmd_t c;
    c.kind    = CMD_REQUEST;
    c.op      = op;
    c.angle   = ang[ANGLE_W-1:0];
    c.reg_idx = '0;
    c.reg_val = '0;
    pending_cmds.push_back(c);
    request_total++;
  endtask

  task automatic queue_reg_write(logic [CFG_IDX_W-1:0] idx, int val);
    sweep_cmd_t c;
    c.kind    = CMD_REG_WRITE;
    c.op      = OP_STEP;
    c.angle   = '0;
    c.reg_idx = idx;
    c.reg_val = val[CFG_W-1:0];
    pending_cmds.push_back(c);
  endtask

  task automatic queue_settings(int max_a, int start_a, int stop_a, int min_p, int max_p,
                                int step, int mode, int delay);
    queue_reg_write(CFG_MAX_ANGLE, max_a);
    queue_reg_write(CFG_START_ANGLE, start_a);
    queue_reg_write(CFG_STOP_ANGLE, stop_a);
    queue_reg_write(CFG_MIN_PULSE, min_p);
    queue_reg_write(CFG_MAX_PULSE, max_p);
    queue_reg_write(CFG_ANGLE_STEP, step);
    queue_reg_write(CFG_INIT_MODE, mode);
    queue_reg_write(CFG_FB_DELAY, delay);
  endtask

  // mostly well-formed sweeps: many step ticks, enough starts and
  // millisecond ticks to get out of one-shot ends and pauses
  task automatic queue_random_requests(int count, int angle_limit);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 46) begin
        queue_request(OP_STEP, $urandom_range(ANGLE_TOP));
      end else if (r < 66) begin
        queue_request(OP_MS, $urandom_range(ANGLE_TOP));
      end else if (r < 78) begin
        queue_request(OP_START, $urandom_range(ANGLE_TOP));
      end else if (r < 82) begin
        queue_request(OP_STOP, $urandom_range(ANGLE_TOP));
      end else if (r < 97) begin
        if ($urandom_range(3) == 0) queue_request(OP_SET, $urandom_range(ANGLE_TOP));
        else queue_request(OP_SET, $urandom_range(angle_limit));
      end else begin
        queue_request($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST), $urandom_range(ANGLE_TOP));
      end
    end
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  // request side: one offer at a time, register writes only once drained
  always @(posedge clk) begin : request_driver
    logic       valid_nxt;
    logic       we_nxt;
    sweep_cmd_t head;
    int         send_gap_left;
    int         send_gap_pct;
    int         idle_cycles;
    valid_nxt = s_tvalid;
    we_nxt    = 1'b0;
    if (rst) begin
      valid_nxt     = 1'b0;
      send_gap_left = 0;
      send_gap_pct  = 0;
      idle_cycles   = 0;
    end else begin
      if ($urandom_range(63) == 0) send_gap_pct = pick_idle_percent();
      if (s_tvalid && s_tready) begin
        expected_reports.push_back(predict_report(s_tuser, s_tdata[ANGLE_W-1:0]));
        requests_sent++;
        valid_nxt = 1'b0;
        if (requests_sent < request_total - TAIL_ITEMS && $urandom_range(99) < send_gap_pct)
          send_gap_left = $urandom_range(14, 1);
      end
      if (expected_reports.size() == 0 && !s_tvalid) idle_cycles++;
      else idle_cycles = 0;

      if (send_gap_left > 0) begin
        if (!valid_nxt) send_gap_left--;
      end else if (!valid_nxt && pending_cmds.size() > 0) begin
        head = pending_cmds[0];
        if (head.kind == CMD_REQUEST) begin
          void'(pending_cmds.pop_front());
          valid_nxt = 1'b1;
          s_tuser   <= head.op;
          s_tdata   <= {{(IN_DATA_W - ANGLE_W){1'b0}}, head.angle};
        end else if (idle_cycles >= SETTLE_CYCLES) begin
          // block is drained: write the register and mirror it in the sweep model
          void'(pending_cmds.pop_front());
          we_nxt    = 1'b1;
          cfg_index <= head.reg_idx;
          cfg_wdata <= head.reg_val;
          case (head.reg_idx)
            CFG_MAX_ANGLE:   max_angle_r   = head.reg_val[ANGLE_W-1:0];
            CFG_START_ANGLE: start_angle_r = head.reg_val[ANGLE_W-1:0];
            CFG_STOP_ANGLE:  stop_angle_r  = head.reg_val[ANGLE_W-1:0];
            CFG_MIN_PULSE:   min_pulse_r   = head.reg_val[PULSE_W-1:0];
            CFG_MAX_PULSE:   max_pulse_r   = head.reg_val[PULSE_W-1:0];
            CFG_ANGLE_STEP:  step_now      = $signed(head.reg_val[STEP_W-1:0]);
            CFG_INIT_MODE: begin
              // codes above bidirectional are stored but leave the mode alone
              if (head.reg_val[MODE_W-1:0] <= MODE_BIDIR) mode_now = head.reg_val[MODE_W-1:0];
            end
            CFG_FB_DELAY:    fb_delay_r    = head.reg_val[DELAY_W-1:0];
            default: ;
          endcase
        end
      end
    end
    s_tvalid <= valid_nxt;
    cfg_we   <= we_nxt;
  end

  // result side: compare against the oldest prediction, stall at random
  always @(posedge clk) begin : report_monitor
    logic          ready_nxt;
    servo_report_t want;
    int            recv_gap_left;
    int            recv_gap_pct;
    int            holdoff_left;
    ready_nxt = 1'b0;
    if (rst) begin
      recv_gap_left = 0;
      recv_gap_pct  = 0;
      holdoff_left  = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, got tdata %0h tuser %0h",
                   $time, m_tdata, m_tuser);
          error_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("position", want.position, m_tdata[ANGLE_W-1:0]);
          check_field("duty", want.duty, m_tdata[ANGLE_W +: DUTY_BITS]);
          check_field("running", want.running, m_tdata[ANGLE_W + DUTY_BITS]);
          check_field("active_mode", want.mode, m_tdata[ANGLE_W + DUTY_BITS + 1 +: MODE_W]);
          check_field("updated", want.updated, m_tuser[FLAG_UPDATED]);
          check_field("error", want.error, m_tuser[FLAG_ERROR]);
        end
        // long back-pressure so the block fills up and stalls its input
        if (reports_seen == HOLDOFF_AT_A || reports_seen == HOLDOFF_AT_B)
          holdoff_left = HOLDOFF_CYCLES;
      end
      if ($urandom_range(63) == 0) recv_gap_pct = pick_idle_percent();
      if (holdoff_left > 0) begin
        holdoff_left--;
      end else if (recv_gap_left > 0) begin
        recv_gap_left--;
      end else if (reports_seen < request_total - TAIL_ITEMS &&
                   $urandom_range(99) < recv_gap_pct) begin
        recv_gap_left = $urandom_range(13, 0);
      end else begin
        ready_nxt = 1'b1;
      end
    end
    m_tready <= ready_nxt;
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int max_a;
    int start_a;
    int min_p;
    int step;

    // reset settings: stopped tick, idle millisecond tick, set-position
    // limits, unknown opcodes, then a one-way clockwise wrap into the pause
    queue_request(OP_STEP, 0);
    queue_request(OP_MS, ANGLE_TOP);
    queue_request(OP_SET, 180);
    queue_request(OP_SET, 181);
    queue_request(OP_SET, ANGLE_TOP);
    queue_request(OP_SET, 0);
    queue_request(OP_UNUSED_FIRST, ANGLE_TOP);
    queue_request(OP_UNUSED_LAST, 0);
    queue_request(OP_START, 0);
    queue_request(OP_STEP, 0);
    queue_request(OP_SET, 180);
    queue_request(OP_STEP, 0);
    queue_request(OP_STEP, 0);
    queue_request(OP_STOP, 0);
    queue_request(OP_START, 0);

    // one-way counter-clockwise: wrap to max, arm, short pause, resume
    queue_settings(90, 10, 80, 1000, 2000, -7, MODE_OW_CCW, 1);
    queue_request(OP_SET, 12);
    queue_request(OP_START, 0);
    queue_request(OP_STEP, 0);
    queue_request(OP_STEP, 0);
    queue_request(OP_MS, 0);
    queue_request(OP_STEP, 0);

    // one-shot clockwise at full range, runs past the stop angle
    queue_settings(360, 0, 360, 0, 20000, 360, MODE_OS_CW, 0);
    queue_request(OP_SET, 0);
    queue_request(OP_START, 0);
    queue_request(OP_STEP, 0);
    queue_request(OP_STEP, 0);

    // bidirectional over a one-degree range, inverted pulse span, longest pause
    queue_settings(1, 0, 1, 20000, 0, -360, MODE_BIDIR, 65535);
    queue_random_requests(PHASE_ITEMS, 1);

    // most negative step, then an out-of-range mode code that must not stick
    queue_settings(200, 20, 150, 700, 2300, -512, MODE_BIDIR, 3);
    queue_reg_write(CFG_INIT_MODE, MODE_UNUSED);
    queue_random_requests(PHASE_ITEMS, 200);

    // zero max angle: pulse pinned at the minimum
    queue_settings(0, 0, 60, 1500, 500, 5, MODE_BIDIR, 2);
    queue_random_requests(PHASE_ITEMS, 0);

    // positions beyond max angle with a falling span drive the pulse negative
    queue_settings(10, 0, 360, 20000, 0, 9, MODE_OW_CW, 2);
    queue_random_requests(PHASE_ITEMS, 10);

    // steep span: duty saturates at the top count
    queue_settings(20, 0, 300, 500, 20000, 7, MODE_BIDIR, 1);
    queue_random_requests(PHASE_ITEMS, 20);

    // zero step: end tests still run but nothing moves
    queue_settings(120, 30, 90, 600, 2400, 0, MODE_OS_CCW, 4);
    queue_random_requests(PHASE_ITEMS, 120);

    for (int ph = 0; ph < 4; ph++) begin
      max_a   = $urandom_range(360, 1);
      start_a = $urandom_range(max_a / 2);
      min_p   = $urandom_range(2500);
      step    = $urandom_range(15, 1);
      if ($urandom_range(1) == 1) step = -step;
      queue_settings(max_a, start_a, $urandom_range(360, start_a + 1), min_p,
                     $urandom_range(20000, min_p), step, $urandom_range(MODE_BIDIR),
                     $urandom_range(5));
      queue_random_requests(PHASE_ITEMS, max_a);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || s_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/sss_pkg.sv
hdl/sss_divider.sv
hdl/sss_datapath.sv
hdl/sss_ctrl.sv
hdl/servo_sweep_sequencer_unit.sv
hdl/sss_checker.sv
bench/tb_top.sv
